### rtl/core/eps_pkg.sv
// shared types, constants and lamp helpers for the emergency preemption sequencer
`default_nettype none

package eps_pkg;

  localparam int LANES      = 4;
  localparam int LAMP_W     = 12;
  localparam int LAMP_LANES = (LANES < LAMP_W / 3) ? LANES : LAMP_W / 3;
  localparam int DUR_W      = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ENTRY_YELLOW = 3'd0;
  localparam logic [2:0] REG_ENTRY_CLEAR  = 3'd1;
  localparam logic [2:0] REG_HOLD         = 3'd2;
  localparam logic [2:0] REG_EXIT_YELLOW  = 3'd3;
  localparam logic [2:0] REG_EXIT_CLEAR   = 3'd4;
  localparam logic [2:0] REG_EXIT_PREP    = 3'd5;

  localparam logic [DUR_W-1:0] RST_ENTRY_YELLOW = 16'd1000;
  localparam logic [DUR_W-1:0] RST_ENTRY_CLEAR  = 16'd200;
  localparam logic [DUR_W-1:0] RST_HOLD         = 16'd5000;
  localparam logic [DUR_W-1:0] RST_EXIT_YELLOW  = 16'd3000;
  localparam logic [DUR_W-1:0] RST_EXIT_CLEAR   = 16'd500;
  localparam logic [DUR_W-1:0] RST_EXIT_PREP    = 16'd1000;

  // lamp phase codes
  localparam logic [1:0] LP_RED       = 2'd0;
  localparam logic [1:0] LP_YELLOW    = 2'd1;
  localparam logic [1:0] LP_YEL_GREEN = 2'd2;
  localparam logic [1:0] LP_GREEN     = 2'd3;

  // request codes
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_OLD_YEL     = 4'd1,
    PH_ENTRY_CLEAR = 4'd2,
    PH_EMERG_PREP  = 4'd3,
    PH_HOLD        = 4'd4,
    PH_EXIT_YEL    = 4'd5,
    PH_EXIT_CLEAR  = 4'd6,
    PH_EXIT_PREP   = 4'd7
  } seq_phase_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] emerg_lane;
    logic [1:0] normal_lane;
    logic [1:0] normal_phase;
  } in_item_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [1:0]        shown_lane;
    logic [1:0]        shown_phase;
    logic              override_active;
    logic              sequence_done;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] entry_yellow_ms;
    logic [DUR_W-1:0] entry_clear_ms;
    logic [DUR_W-1:0] hold_ms;
    logic [DUR_W-1:0] exit_yellow_ms;
    logic [DUR_W-1:0] exit_clear_ms;
    logic [DUR_W-1:0] exit_prep_ms;
  } dur_cfg_t;

  // a zero duration behaves as one tick
  function automatic logic [DUR_W-1:0] dur(input logic [DUR_W-1:0] r);
    return (r == '0) ? DUR_W'(1) : r;
  endfunction

  // named lane in its phase, every other lane red; with all_red set, every lane red
  function automatic logic [LAMP_W-1:0] lamp_word(input logic [1:0] lane,
                                                  input logic [1:0] ph,
                                                  input logic       all_red);
    logic [LAMP_W-1:0] w;
    w = '0;
    for (int i = 0; i < LAMP_LANES; i++) begin
      if (!all_red && (2'(i) == lane)) begin
        case (ph)
          LP_GREEN: w[3*i +: 3] = 3'b100;
          LP_RED:   w[3*i +: 3] = 3'b001;
          default:  w[3*i +: 3] = 3'b010;
        endcase
      end else begin
        w[3*i +: 3] = 3'b001;
      end
    end
    return w;
  endfunction

  function automatic out_item_t show_item(input seq_phase_t ph,
                                          input logic [1:0] saved_lane,
                                          input logic [1:0] emerg_lane);
    out_item_t  o;
    logic [1:0] lane;
    logic [1:0] lp;
    logic       all_red;
    all_red = 1'b0;
    case (ph)
      PH_OLD_YEL: begin
        lane = saved_lane; lp = LP_YELLOW;
      end
      PH_ENTRY_CLEAR: begin
        lane = saved_lane; lp = LP_RED; all_red = 1'b1;
      end
      PH_EMERG_PREP: begin
        lane = emerg_lane; lp = LP_YEL_GREEN;
      end
      PH_HOLD: begin
        lane = emerg_lane; lp = LP_GREEN;
      end
      PH_EXIT_YEL: begin
        lane = emerg_lane; lp = LP_YELLOW;
      end
      PH_EXIT_CLEAR: begin
        lane = emerg_lane; lp = LP_RED; all_red = 1'b1;
      end
      default: begin
        lane = saved_lane; lp = LP_YEL_GREEN;
      end
    endcase
    o.lamps           = lamp_word(lane, lp, all_red);
    o.shown_lane      = lane;
    o.shown_phase     = lp;
    o.override_active = 1'b1;
    o.sequence_done   = 1'b0;
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/core/eps_regs.sv
// configuration register file behind the apb-style port
`default_nettype none

module eps_regs
  import eps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output dur_cfg_t               cfg
);

  dur_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;
  logic [DUR_W-1:0] rd_val;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_yellow_ms <= RST_ENTRY_YELLOW;
      cfg_r.entry_clear_ms  <= RST_ENTRY_CLEAR;
      cfg_r.hold_ms         <= RST_HOLD;
      cfg_r.exit_yellow_ms  <= RST_EXIT_YELLOW;
      cfg_r.exit_clear_ms   <= RST_EXIT_CLEAR;
      cfg_r.exit_prep_ms    <= RST_EXIT_PREP;
    end else if (wr_en) begin
      case (idx)
        REG_ENTRY_YELLOW: cfg_r.entry_yellow_ms <= pwdata[DUR_W-1:0];
        REG_ENTRY_CLEAR:  cfg_r.entry_clear_ms  <= pwdata[DUR_W-1:0];
        REG_HOLD:         cfg_r.hold_ms         <= pwdata[DUR_W-1:0];
        REG_EXIT_YELLOW:  cfg_r.exit_yellow_ms  <= pwdata[DUR_W-1:0];
        REG_EXIT_CLEAR:   cfg_r.exit_clear_ms   <= pwdata[DUR_W-1:0];
        REG_EXIT_PREP:    cfg_r.exit_prep_ms    <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENTRY_YELLOW: rd_val = cfg_r.entry_yellow_ms;
      REG_ENTRY_CLEAR:  rd_val = cfg_r.entry_clear_ms;
      REG_HOLD:         rd_val = cfg_r.hold_ms;
      REG_EXIT_YELLOW:  rd_val = cfg_r.exit_yellow_ms;
      REG_EXIT_CLEAR:   rd_val = cfg_r.exit_clear_ms;
      REG_EXIT_PREP:    rd_val = cfg_r.exit_prep_ms;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-DUR_W){1'b0}}, rd_val};
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

### rtl/core/emergency_preemption_sequencer_top.sv
// top level: emergency preemption state machine with registered result
// each input transfer writes its result into the output register
// throughput: one item per cycle while in_stall is low; the state machine updates in the transfer cycle
// in_stall rises only while a finished result sits in the output register and out_stall is high
// reset (rst_n low, synchronous): sequencer idle, timer and saved lanes zero, no pending
// trigger, output register empty, duration registers back to their default values
`default_nettype none

module emergency_preemption_sequencer_top
  import eps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  dur_cfg_t cfg;

  eps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer state
  seq_phase_t       phase_r, phase_nxt;
  logic [DUR_W-1:0] timer_r, timer_nxt;
  logic [1:0]       saved_lane_r, saved_lane_nxt;
  logic [1:0]       saved_phase_r, saved_phase_nxt;
  logic [1:0]       emerg_lane_r, emerg_lane_nxt;
  logic             direct_r, direct_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       pend_lane_r, pend_lane_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic in_fire;
  logic trig;

  // the output register frees itself when its result is taken, so a new item
  // may transfer in the same cycle as the old result leaves
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign trig     = (in_data.req_type == REQ_TRIGGER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      timer_r       <= '0;
      saved_lane_r  <= '0;
      saved_phase_r <= '0;
      emerg_lane_r  <= '0;
      direct_r      <= 1'b0;
      pend_r        <= 1'b0;
      pend_lane_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      timer_r       <= timer_nxt;
      saved_lane_r  <= saved_lane_nxt;
      saved_phase_r <= saved_phase_nxt;
      emerg_lane_r  <= emerg_lane_nxt;
      direct_r      <= direct_nxt;
      pend_r        <= pend_nxt;
      pend_lane_r   <= pend_lane_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload register needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic [1:0] st_lane;
    logic [1:0] st_phase;
    logic [1:0] st_emerg;
    logic       do_start;
    logic       done;
    logic [1:0] done_ph;
    logic       st_direct;

    phase_nxt       = phase_r;
    timer_nxt       = timer_r;
    saved_lane_nxt  = saved_lane_r;
    saved_phase_nxt = saved_phase_r;
    emerg_lane_nxt  = emerg_lane_r;
    direct_nxt      = direct_r;
    pend_nxt        = pend_r;
    pend_lane_nxt   = pend_lane_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r & out_stall;

    do_start  = 1'b0;
    done      = 1'b0;
    st_lane   = in_data.normal_lane;
    st_phase  = in_data.normal_phase;
    st_emerg  = in_data.emerg_lane;
    st_direct = 1'b0;
    done_ph   = direct_r ? saved_phase_r : LP_GREEN;

    if (in_fire) begin
      if (phase_r == PH_IDLE) begin
        // idle: a trigger starts a sequence, a tick leaves the sequencer idle
        do_start = trig;
      end else if (trig) begin
        // trigger during a sequence: remember the latest lane only
        pend_nxt      = 1'b1;
        pend_lane_nxt = in_data.emerg_lane;
      end else if (timer_r > DUR_W'(1)) begin
        timer_nxt = timer_r - DUR_W'(1);
      end else begin
        // timer expired: advance to the next phase, or back to idle
        timer_nxt = '0;
        case (phase_r)
          PH_OLD_YEL: begin
            phase_nxt = PH_ENTRY_CLEAR; timer_nxt = dur(cfg.entry_clear_ms);
          end
          PH_ENTRY_CLEAR: begin
            phase_nxt = PH_EMERG_PREP; timer_nxt = dur(cfg.entry_yellow_ms);
          end
          PH_EMERG_PREP: begin
            phase_nxt = PH_HOLD; timer_nxt = dur(cfg.hold_ms);
          end
          PH_HOLD: begin
            if (!direct_r) begin
              phase_nxt = PH_EXIT_YEL; timer_nxt = dur(cfg.exit_yellow_ms);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_EXIT_YEL: begin
            phase_nxt = PH_EXIT_CLEAR; timer_nxt = dur(cfg.exit_clear_ms);
          end
          PH_EXIT_CLEAR: begin
            phase_nxt = PH_EXIT_PREP; timer_nxt = dur(cfg.exit_prep_ms);
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (phase_nxt == PH_IDLE) begin
          if (pend_r) begin
            // chained sequence starts from the restored lane in green
            pend_nxt = 1'b0;
            do_start = 1'b1;
            st_lane  = saved_lane_r;
            st_phase = LP_GREEN;
            st_emerg = pend_lane_r;
          end else begin
            done = 1'b1;
          end
        end
      end

      if (do_start) begin
        st_direct       = (st_lane == st_emerg) && (st_phase == LP_GREEN);
        saved_lane_nxt  = st_lane;
        saved_phase_nxt = st_phase;
        emerg_lane_nxt  = st_emerg;
        direct_nxt      = st_direct;
        if (st_direct) begin
          phase_nxt = PH_HOLD;        timer_nxt = dur(cfg.hold_ms);
        end else if (st_phase == LP_GREEN || st_phase == LP_YEL_GREEN) begin
          phase_nxt = PH_OLD_YEL;     timer_nxt = dur(cfg.entry_yellow_ms);
        end else begin
          phase_nxt = PH_ENTRY_CLEAR; timer_nxt = dur(cfg.entry_clear_ms);
        end
      end

      // result reflects the state after this item
      if (phase_nxt != PH_IDLE) begin
        out_data_nxt = show_item(phase_nxt, saved_lane_nxt, emerg_lane_nxt);
      end else if (done) begin
        out_data_nxt.lamps           = lamp_word(saved_lane_r, done_ph, 1'b0);
        out_data_nxt.shown_lane      = saved_lane_r;
        out_data_nxt.shown_phase     = done_ph;
        out_data_nxt.override_active = 1'b0;
        out_data_nxt.sequence_done   = 1'b1;
      end else begin
        out_data_nxt = '0;
      end
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/eps_checker.sv
// port-level checker for the emergency preemption sequencer, bound to the top level
`default_nettype none

module eps_checker
  import eps_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // input is held back only while a result waits in the output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // completion hands the lamps back
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sequence_done |-> !out_data.override_active)
    else $error("sequence done while still overriding");

  // outside a sequence and not completing, lamps are dark
  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.override_active && !out_data.sequence_done
      |-> out_data.lamps == '0)
    else $error("lamps driven while idle");

endmodule

bind emergency_preemption_sequencer_top eps_checker u_eps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
